@@ hdl/cit_pkg.sv @@
// Shared types and constants for the interrupt and timer controller.
package cit_pkg;

	// Decrementer width
	localparam int unsigned COUNT_BITS = 14;

	// Interrupt enable / pending mask width
	localparam int unsigned MASK_BITS = 15;

	// Decrementer interrupt (interrupt 3) sits at mask bit 2
	localparam int unsigned INT3_IDX = 2;

	// Serial bit addresses
	localparam logic [4:0] ADDR_MODE          = 5'd0;
	localparam logic [4:0] ADDR_LAST_INTERVAL = 5'd14;
	localparam logic [4:0] ADDR_LAST_MASK     = 5'd15;
	localparam logic [4:0] ADDR_COL0          = 5'd18;
	localparam logic [4:0] ADDR_COL1          = 5'd19;
	localparam logic [4:0] ADDR_COL2          = 5'd20;
	localparam logic [4:0] ADDR_ALPHA         = 5'd21;
	localparam logic [4:0] ADDR_GATE          = 5'd24;
	localparam logic [4:0] ADDR_TAPE          = 5'd25;

	// Byte read groups
	localparam logic [1:0] GRP_LOW  = 2'd0;
	localparam logic [1:0] GRP_HIGH = 2'd1;
	localparam logic [1:0] GRP_KEYS = 2'd2;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_LINES = 2'd3
	} func_t;

endpackage

@@ hdl/cru_interrupt_timer_controller.sv @@
// Serial-bit-addressed interrupt and timer controller, top level.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per operation:
//   func selects a bit write, a byte read, a decrementer tick or an
//   interrupt line update; the other fields are operands of that operation.
//   Output channel (out_valid / out_stall) returns exactly one beat per
//   input beat: the byte read (zero for non-reads), the interrupt request
//   and the keyboard column, audio gate and cassette pin levels after the
//   operation.
//   An accepted beat passes through the input register, then the result
//   register, and waits in either while the output is stalled.
//   Throughput: one beat per cycle while the output is not stalled; the
//   state update is a single read-modify-write of small registers done
//   between the input register and the result register.
//   Reset (arst_n low) clears all state: I/O mode, decrementer stopped,
//   masks and pending bits clear, pins low, both pipeline stages empty.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds its item; in_stall rises only when both are full
//   and out_stall is high, so nothing is lost or repeated.
module cru_interrupt_timer_controller (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [4:0] cru_bit,
	input  logic       bit_value,
	input  logic [1:0] read_group,
	input  logic [7:0] key_lines,
	input  logic       alpha_key,
	input  logic [1:0] ext_lines,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_out,
	output logic [2:0] key_column,
	output logic       audio_gate,
	output logic       tape_out
);

	localparam int unsigned CW = cit_pkg::COUNT_BITS;
	localparam int unsigned MW = cit_pkg::MASK_BITS;

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [4:0] cru_bit_s1;
	logic       bit_value_s1;
	logic [1:0] read_group_s1;
	logic [7:0] key_lines_s1;
	logic       alpha_key_s1;
	logic [1:0] ext_lines_s1;

	logic       out_valid_q;
	logic       can_move;
	logic       fire;
	logic       in_take;

	// result register free, or being drained this cycle
	assign can_move = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && can_move;
	assign in_stall = valid_s1 && !can_move;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1       <= func;
			cru_bit_s1    <= cru_bit;
			bit_value_s1  <= bit_value;
			read_group_s1 <= read_group;
			key_lines_s1  <= key_lines;
			alpha_key_s1  <= alpha_key;
			ext_lines_s1  <= ext_lines;
		end
	end

	// ---------------------------------------------------------------
	// Architectural state
	// ---------------------------------------------------------------
	logic          timer_mode_q,     timer_mode_n;
	logic [CW-1:0] latched_count_q,  latched_count_n;
	logic [CW-1:0] interval_q,       interval_n;
	logic          interval_dirty_q, interval_dirty_n;
	logic [CW-1:0] down_count_q,     down_count_n;
	logic [MW-1:0] enable_mask_q,    enable_mask_n;
	logic [MW-1:0] pending_mask_q,   pending_mask_n;
	logic [MW-1:0] prior_active_q,   prior_active_n;
	logic [1:0]    line_levels_q,    line_levels_n;
	logic [2:0]    column_select_q,  column_select_n;
	logic          alpha_line_q,     alpha_line_n;
	logic          gate_level_q,     gate_level_n;
	logic          tape_level_q,     tape_level_n;

	logic [7:0]    rdata;
	logic          do_eval;
	logic          leave;
	logic [4:0]    bit_idx;
	logic [MW-1:0] active;
	logic [MW-1:0] pend_pre;
	logic [CW+13:0] lat_wide;
	logic [13:0]   lat14;

	// latched count seen as 14 bits for the byte reads
	assign lat_wide = {14'd0, latched_count_q};
	assign lat14    = lat_wide[13:0];
	assign bit_idx  = cru_bit_s1 - 5'd1;

	always_comb begin
		timer_mode_n     = timer_mode_q;
		latched_count_n  = latched_count_q;
		interval_n       = interval_q;
		interval_dirty_n = interval_dirty_q;
		down_count_n     = down_count_q;
		enable_mask_n    = enable_mask_q;
		pend_pre         = pending_mask_q;
		line_levels_n    = line_levels_q;
		column_select_n  = column_select_q;
		alpha_line_n     = alpha_line_q;
		gate_level_n     = gate_level_q;
		tape_level_n     = tape_level_q;
		rdata            = 8'd0;
		do_eval          = 1'b0;
		leave            = 1'b0;

		case (cit_pkg::func_t'(func_s1))
			cit_pkg::FUNC_WRITE: begin
				if (cru_bit_s1 == cit_pkg::ADDR_MODE) begin
					if (timer_mode_q != bit_value_s1) begin
						timer_mode_n = bit_value_s1;
						if (bit_value_s1) begin
							latched_count_n  = down_count_q;
							interval_dirty_n = 1'b0;
						end else if (interval_dirty_q) begin
							down_count_n = interval_q;
						end
					end
				end else if (cru_bit_s1 <= cit_pkg::ADDR_LAST_MASK) begin
					if (timer_mode_q) begin
						// bit 15 (soft reset) ignored; bits past the counter dropped
						if (cru_bit_s1 <= cit_pkg::ADDR_LAST_INTERVAL) begin
							for (int i = 0; i < CW; i++) begin
								if (bit_idx == 5'(i)) begin
									interval_n[i] = bit_value_s1;
								end
							end
							interval_dirty_n = 1'b1;
						end
					end else begin
						enable_mask_n[bit_idx[3:0]] = bit_value_s1;
						pend_pre[bit_idx[3:0]]      = 1'b0;
						do_eval                     = 1'b1;
					end
				end else begin
					leave = 1'b1;
					case (cru_bit_s1)
						cit_pkg::ADDR_COL0:  column_select_n[0] = bit_value_s1;
						cit_pkg::ADDR_COL1:  column_select_n[1] = bit_value_s1;
						cit_pkg::ADDR_COL2:  column_select_n[2] = bit_value_s1;
						cit_pkg::ADDR_ALPHA: alpha_line_n       = bit_value_s1;
						cit_pkg::ADDR_GATE:  gate_level_n       = bit_value_s1;
						cit_pkg::ADDR_TAPE:  tape_level_n       = bit_value_s1;
						default: ;
					endcase
				end
			end
			cit_pkg::FUNC_READ: begin
				case (read_group_s1)
					cit_pkg::GRP_LOW: begin
						if (timer_mode_q) begin
							rdata = {lat14[6:0], 1'b1};
						end else begin
							rdata = {key_lines_s1[4:0], !line_levels_q[1],
								!line_levels_q[0], 1'b0};
							if (!alpha_line_q && alpha_key_s1) begin
								rdata[3] = 1'b0;
							end
						end
					end
					cit_pkg::GRP_HIGH: begin
						if (timer_mode_q) begin
							rdata = {~|(pending_mask_q & enable_mask_q), lat14[13:7]};
						end else begin
							rdata = {5'd0, key_lines_s1[7:5]};
						end
					end
					cit_pkg::GRP_KEYS: begin
						leave = 1'b1;
						rdata = {2'd0, !alpha_line_q, column_select_q, 2'd0};
					end
					default: begin
						leave = 1'b1;
					end
				endcase
			end
			cit_pkg::FUNC_TICK: begin
				if (down_count_q == CW'(1)) begin
					if (enable_mask_q[cit_pkg::INT3_IDX]) begin
						pend_pre[cit_pkg::INT3_IDX] = 1'b1;
						do_eval                     = 1'b1;
					end
					down_count_n = interval_q;
				end else if (down_count_q != '0) begin
					down_count_n = down_count_q - CW'(1);
				end
			end
			default: begin
				line_levels_n = ext_lines_s1;
				do_eval       = 1'b1;
			end
		endcase

		// leaving timer mode reloads the decrementer if the interval changed
		if (leave && timer_mode_q) begin
			timer_mode_n = 1'b0;
			if (interval_dirty_q) begin
				down_count_n = interval_q;
			end
		end

		// edge detection on line AND mask
		active         = {{(MW-2){1'b0}}, line_levels_n} & enable_mask_n;
		pending_mask_n = pend_pre;
		prior_active_n = prior_active_q;
		if (do_eval) begin
			pending_mask_n = pend_pre | (active & ~prior_active_q);
			prior_active_n = active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_mode_q     <= 1'b0;
			latched_count_q  <= '0;
			interval_q       <= '0;
			interval_dirty_q <= 1'b0;
			down_count_q     <= '0;
			enable_mask_q    <= '0;
			pending_mask_q   <= '0;
			prior_active_q   <= '0;
			line_levels_q    <= '0;
			column_select_q  <= '0;
			alpha_line_q     <= 1'b0;
			gate_level_q     <= 1'b0;
			tape_level_q     <= 1'b0;
		end else if (fire) begin
			timer_mode_q     <= timer_mode_n;
			latched_count_q  <= latched_count_n;
			interval_q       <= interval_n;
			interval_dirty_q <= interval_dirty_n;
			down_count_q     <= down_count_n;
			enable_mask_q    <= enable_mask_n;
			pending_mask_q   <= pending_mask_n;
			prior_active_q   <= prior_active_n;
			line_levels_q    <= line_levels_n;
			column_select_q  <= column_select_n;
			alpha_line_q     <= alpha_line_n;
			gate_level_q     <= gate_level_n;
			tape_level_q     <= tape_level_n;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [7:0] read_data_q;
	logic       irq_q;
	logic [2:0] key_column_q;
	logic       audio_gate_q;
	logic       tape_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q  <= rdata;
			irq_q        <= |pending_mask_n;
			key_column_q <= column_select_n;
			audio_gate_q <= gate_level_n;
			tape_out_q   <= tape_level_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign irq_out    = irq_q;
	assign key_column = key_column_q;
	assign audio_gate = audio_gate_q;
	assign tape_out   = tape_out_q;

endmodule

@@ hdl/cit_checker.sv @@
// Port-level checker for the interrupt and timer controller, with its bind.
module cit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] func,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       irq_out,
	input logic [2:0] key_column,
	input logic       audio_gate,
	input logic       tape_out
);

	// held beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq_out)
			&& $stable(key_column) && $stable(audio_gate) && $stable(tape_out))
		else $error("stalled output beat changed");

	// input only backs up when the result register is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled output beat");

	// an accepted beat reaches the output when the receiver is free; non-reads return zero
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result beat missing after two cycles");

	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func != cit_pkg::FUNC_READ) ##1 !out_stall
			|=> read_data == 8'd0)
		else $error("non-read beat returned nonzero data");

endmodule

bind cru_interrupt_timer_controller cit_checker u_cit_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data),
	.irq_out    (irq_out),
	.key_column (key_column),
	.audio_gate (audio_gate),
	.tape_out   (tape_out)
);

@@ dv/cit_result_checker.sv @@
`timescale 1ns / 1ps
// Output checker for the interrupt and timer controller: tracks its state and compares each result beat.
module cit_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] func,
	input  logic [4:0] cru_bit,
	input  logic       bit_value,
	input  logic [1:0] read_group,
	input  logic [7:0] key_lines,
	input  logic       alpha_key,
	input  logic [1:0] ext_lines,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_data,
	input  logic       irq_out,
	input  logic [2:0] key_column,
	input  logic       audio_gate,
	input  logic       tape_out,
	output int         failures,
	output int         outstanding
);

	typedef struct packed {
		logic [7:0] data;
		logic       irq;
		logic [2:0] column;
		logic       gate;
		logic       tape;
	} pin_beat_t;

	logic                           timer_on;
	logic [cit_pkg::COUNT_BITS-1:0] snap;
	logic [cit_pkg::COUNT_BITS-1:0] period;
	logic                           period_dirty;
	logic [cit_pkg::COUNT_BITS-1:0] count;
	logic [cit_pkg::MASK_BITS-1:0]  enables;
	logic [cit_pkg::MASK_BITS-1:0]  pends;
	logic [cit_pkg::MASK_BITS-1:0]  seen_active;
	logic [1:0]                     lines;
	logic [2:0]                     column;
	logic                           alpha_lock;
	logic                           gate;
	logic                           tape;

	pin_beat_t awaited_beats[$];
	int        errors = 0;

	task automatic clear_state();
		timer_on = 1'b0;
		snap = '0;
		period = '0;
		period_dirty = 1'b0;
		count = '0;
		enables = '0;
		pends = '0;
		seen_active = '0;
		lines = '0;
		column = '0;
		alpha_lock = 1'b0;
		gate = 1'b0;
		tape = 1'b0;
	endtask

	// pend on rising edges of line AND enable
	task automatic latch_edges();
		logic [cit_pkg::MASK_BITS-1:0] active;
		active = cit_pkg::MASK_BITS'(lines) & enables;
		pends = pends | (active & ~seen_active);
		seen_active = active;
	endtask

	task automatic drop_timer_mode();
		if (timer_on) begin
			timer_on = 1'b0;
			if (period_dirty)
				count = period;
		end
	endtask

	task automatic write_bit(input logic [4:0] addr, input logic v);
		logic [3:0] idx;
		idx = 4'(addr - 5'd1);
		if (addr == cit_pkg::ADDR_MODE) begin
			if (timer_on != v) begin
				timer_on = v;
				if (v) begin
					snap = count;
					period_dirty = 1'b0;
				end else if (period_dirty) begin
					count = period;
				end
			end
		end else if (addr <= cit_pkg::ADDR_LAST_MASK) begin
			if (timer_on) begin
				// bit 15 is soft reset here and does nothing
				if (addr <= cit_pkg::ADDR_LAST_INTERVAL) begin
					if (idx < cit_pkg::COUNT_BITS)
						period[idx] = v;
					period_dirty = 1'b1;
				end
			end else begin
				enables[idx] = v;
				pends[idx] = 1'b0;
				latch_edges();
			end
		end else begin
			drop_timer_mode();
			case (addr)
				cit_pkg::ADDR_COL0:  column[0] = v;
				cit_pkg::ADDR_COL1:  column[1] = v;
				cit_pkg::ADDR_COL2:  column[2] = v;
				cit_pkg::ADDR_ALPHA: alpha_lock = v;
				cit_pkg::ADDR_GATE:  gate = v;
				cit_pkg::ADDR_TAPE:  tape = v;
				default: ;
			endcase
		end
	endtask

	task automatic read_byte(input logic [1:0] grp, input logic [7:0] keys, input logic ak,
			output logic [7:0] b);
		logic [15:0] wide;
		wide = 16'(snap);
		b = '0;
		if (grp == cit_pkg::GRP_LOW) begin
			if (timer_on) begin
				b = {wide[6:0], 1'b1};
			end else begin
				b = {keys[4:0], ~lines[1], ~lines[0], 1'b0};
				if (!alpha_lock && ak)
					b[3] = 1'b0;
			end
		end else if (grp == cit_pkg::GRP_HIGH) begin
			if (timer_on) begin
				b = {1'b0, wide[13:7]};
				if ((pends & enables) == '0)
					b[7] = 1'b1;
			end else begin
				b = {5'b0, keys[7:5]};
			end
		end else begin
			drop_timer_mode();
			if (grp == cit_pkg::GRP_KEYS)
				b = {2'b0, ~alpha_lock, column, 2'b00};
		end
	endtask

	task automatic decrement();
		if (count != '0) begin
			if (count == cit_pkg::COUNT_BITS'(1)) begin
				if (enables[cit_pkg::INT3_IDX]) begin
					pends[cit_pkg::INT3_IDX] = 1'b1;
					latch_edges();
				end
				count = period;
			end else begin
				count = count - 1'b1;
			end
		end
	endtask

	task automatic advance_controller(output pin_beat_t r);
		logic [7:0] rd;
		rd = '0;
		case (cit_pkg::func_t'(func))
			cit_pkg::FUNC_WRITE: write_bit(cru_bit, bit_value);
			cit_pkg::FUNC_READ:  read_byte(read_group, key_lines, alpha_key, rd);
			cit_pkg::FUNC_TICK:  decrement();
			cit_pkg::FUNC_LINES: begin
				lines = ext_lines;
				latch_edges();
			end
			default: ;
		endcase
		r = {rd, |pends, column, gate, tape};
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_beat_t want;
		pin_beat_t got;
		if (!arst_n) begin
			clear_state();
			awaited_beats.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_controller(want);
				awaited_beats.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = {read_data, irq_out, key_column, audio_gate, tape_out};
				if (awaited_beats.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, actual %0h", $time, got);
				end else begin
					want = awaited_beats.pop_front();
					compare_field("read_data", want.data, got.data);
					compare_field("irq_out", 8'(want.irq), 8'(got.irq));
					compare_field("key_column", 8'(want.column), 8'(got.column));
					compare_field("audio_gate", 8'(want.gate), 8'(got.gate));
					compare_field("tape_out", 8'(want.tape), 8'(got.tape));
				end
			end
			outstanding <= awaited_beats.size();
		end
		failures <= errors;
	end

endmodule

@@ dv/tb_cru_interrupt_timer_controller.sv @@
`timescale 1ns / 1ps
// Testbench top for the interrupt and timer controller: stimulus, idling and verdict.
module tb_cru_interrupt_timer_controller;

	// Beats to send in all, directed part included
	localparam int TOTAL_BEATS = 830;
	// Idling stops for the last stretch of the run
	localparam int CALM_BEATS  = 100;
	// Cycle limit for the whole run, well above the worst case
	localparam int CYCLE_LIMIT = 400_000;

	// Bit addresses and a read group not named in the package
	localparam logic [4:0] ADDR_LINE1   = 5'd1;
	localparam logic [4:0] ADDR_LINE2   = 5'd2;
	localparam logic [4:0] ADDR_INT3_EN = 5'(cit_pkg::INT3_IDX + 1);
	localparam logic [4:0] ADDR_LAST    = 5'd31;
	localparam logic [1:0] GRP_SPARE    = 2'd3;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	cit_pkg::func_t  func = cit_pkg::FUNC_WRITE;
	logic [4:0]      cru_bit = '0;
	logic            bit_value = 1'b0;
	logic [1:0]      read_group = '0;
	logic [7:0]      key_lines = '0;
	logic            alpha_key = 1'b0;
	logic [1:0]      ext_lines = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [7:0]      read_data;
	logic            irq_out;
	logic [2:0]      key_column;
	logic            audio_gate;
	logic            tape_out;

	int failures;
	int outstanding;
	int cycles = 0;
	int sent = 0;
	int sent_by_func[4] = '{0, 0, 0, 0};
	bit calm = 1'b0;
	bit drained = 1'b0;

	cru_interrupt_timer_controller i_dut (.*);

	// Watches both channels, predicts every result and counts mismatches
	cit_result_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_cru_interrupt_timer_controller: FAIL");
			$finish;
		end
	end

	// Receiver: free-running stretches broken by stall bursts, none once calm
	initial begin
		forever begin
			if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Sends one beat, sometimes after an idle burst, and waits for acceptance.
	// in_valid stays high afterwards so back-to-back beats need no re-raise.
	task automatic issue(input cit_pkg::func_t f, input logic [4:0] a, input logic v,
			input logic [1:0] g, input logic [7:0] k, input logic ak, input logic [1:0] e);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		cru_bit    <= a;
		bit_value  <= v;
		read_group <= g;
		key_lines  <= k;
		alpha_key  <= ak;
		ext_lines  <= e;
		do @(posedge clk); while (in_stall);
		sent++;
		sent_by_func[f]++;
		if (sent >= TOTAL_BEATS - CALM_BEATS)
			calm = 1'b1;
	endtask

	// Same, with key matrix and alpha key left random
	task automatic put(input cit_pkg::func_t f, input logic [4:0] a, input logic v,
			input logic [1:0] g, input logic [1:0] e);
		issue(f, a, v, g, 8'($urandom), 1'($urandom), e);
	endtask

	// Hold the sender off until every outstanding result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Program an interval in timer mode, usually leave by one of the routes, then
	// run the decrementer. Low interval bits carry the content so that it
	// expires often; the upper bits are mostly cleared.
	task automatic timer_session();
		logic [4:0] a;
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 1; i <= 14; i++)
				put(cit_pkg::FUNC_WRITE, 5'(i),
					(i <= 4 || $urandom_range(0, 15) == 0) ? 1'($urandom) : 1'b0,
					cit_pkg::GRP_LOW, 2'b00);
		end else begin
			repeat ($urandom_range(1, 4)) begin
				a = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(5, 15))
					: 5'($urandom_range(1, 4));
				put(cit_pkg::FUNC_WRITE, a,
					(a <= 5'd4) ? 1'($urandom) : ($urandom_range(0, 3) == 0),
					cit_pkg::GRP_LOW, 2'b00);
			end
		end
		// latched count reads and ticks while still in timer mode
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 1) == 0)
				put(cit_pkg::FUNC_TICK, 5'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom));
			else
				put(cit_pkg::FUNC_READ, 5'($urandom), 1'($urandom),
					2'($urandom_range(0, 1)), 2'($urandom));
		end
		case ($urandom_range(0, 4))
			0, 1: put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
			2: put(cit_pkg::FUNC_WRITE, 5'($urandom_range(16, 31)), 1'($urandom),
				cit_pkg::GRP_LOW, 2'b00);
			3: put(cit_pkg::FUNC_READ, 5'($urandom), 1'($urandom), 2'($urandom_range(2, 3)),
				2'b00);
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0)
			put(cit_pkg::FUNC_WRITE, ADDR_INT3_EN, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		repeat ($urandom_range(1, 40)) begin
			case ($urandom_range(0, 9))
				0: put(cit_pkg::FUNC_READ, 5'($urandom), 1'($urandom),
					2'($urandom_range(0, 1)), 2'($urandom));
				// outside timer mode, rewriting the enable clears a pending decrementer interrupt
				1: put(cit_pkg::FUNC_WRITE, ADDR_INT3_EN, 1'b1, cit_pkg::GRP_LOW, 2'b00);
				default: put(cit_pkg::FUNC_TICK, 5'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom));
			endcase
		end
	endtask

	// External lines and their enables, with reads of the line status and ticks
	task automatic line_session();
		repeat ($urandom_range(4, 12)) begin
			case ($urandom_range(0, 5))
				0, 1: put(cit_pkg::FUNC_LINES, 5'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom));
				2: put(cit_pkg::FUNC_WRITE, 5'($urandom_range(1, 2)), 1'($urandom),
					cit_pkg::GRP_LOW, 2'b00);
				3: put(cit_pkg::FUNC_WRITE, 5'($urandom_range(1, 15)), 1'($urandom),
					cit_pkg::GRP_LOW, 2'b00);
				4: put(cit_pkg::FUNC_READ, 5'($urandom), 1'($urandom),
					2'($urandom_range(0, 1)), 2'($urandom));
				default: put(cit_pkg::FUNC_TICK, 5'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom));
			endcase
		end
	endtask

	// Keyboard column, alpha lock and output pins, then a read of column and alpha lock
	task automatic pin_session();
		repeat ($urandom_range(2, 6))
			put(cit_pkg::FUNC_WRITE, 5'($urandom_range(16, 31)), 1'($urandom),
				cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_READ, 5'($urandom), 1'($urandom), cit_pkg::GRP_KEYS, 2'($urandom));
	endtask

	// Anything at all
	task automatic noise_session();
		repeat ($urandom_range(3, 8))
			issue(cit_pkg::func_t'($urandom_range(0, 3)), 5'($urandom), 1'($urandom),
				2'($urandom), 8'($urandom), 1'($urandom), 2'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads straight after reset, alpha key masking bit 3
		issue(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 8'hFF, 1'b1,
			2'b00);
		issue(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_HIGH, 8'hE0, 1'b0,
			2'b00);
		issue(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, GRP_SPARE, 8'h00, 1'b0, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_LAST_MASK, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_INT3_EN, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		// Timer mode: lowest and highest interval bits, soft reset bit ignored
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_LINE1, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_LAST_INTERVAL, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_LAST_MASK, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_HIGH, 2'b00);
		// Interval of one, reloaded on leaving: every tick expires
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_LAST_INTERVAL, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_TICK, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_TICK, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		// Both lines high before and after their enables
		put(cit_pkg::FUNC_LINES, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b11);
		put(cit_pkg::FUNC_WRITE, ADDR_LINE1, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_LINE2, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_INT3_EN, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		// Every pin bit set, column at its top value
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_COL0, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_COL1, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_COL2, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_ALPHA, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_GATE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_TAPE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		issue(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 8'h1F, 1'b1,
			2'b00);
		put(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_KEYS, 2'b00);
		// Zero interval stops the decrementer; leave by a high bit write
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_LINE1, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_WRITE, ADDR_LAST, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_TICK, cit_pkg::ADDR_MODE, 1'b0, cit_pkg::GRP_LOW, 2'b00);
		// Leave timer mode by a spare group read
		put(cit_pkg::FUNC_WRITE, cit_pkg::ADDR_MODE, 1'b1, cit_pkg::GRP_LOW, 2'b00);
		put(cit_pkg::FUNC_READ, cit_pkg::ADDR_MODE, 1'b0, GRP_SPARE, 2'b00);

		// Random part, mostly well-formed sessions with random content
		while (sent < TOTAL_BEATS) begin
			if (!drained && sent >= TOTAL_BEATS / 2) begin
				drain();
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 8: timer_session();
				4, 5: line_session();
				6: pin_session();
				default: noise_session();
			endcase
		end

		drain();
		repeat (5) @(posedge clk);
		$display("Sent %0d beats: %0d bit writes, %0d byte reads, %0d ticks, %0d line updates.",
			sent, sent_by_func[cit_pkg::FUNC_WRITE], sent_by_func[cit_pkg::FUNC_READ],
			sent_by_func[cit_pkg::FUNC_TICK], sent_by_func[cit_pkg::FUNC_LINES]);
		$display("Timer programming, interrupt edges and pin writes ran under random idling.");
		if (failures == 0 && outstanding == 0)
			$display("tb_cru_interrupt_timer_controller: PASS");
		else
			$display("tb_cru_interrupt_timer_controller: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/cit_pkg.sv
hdl/cru_interrupt_timer_controller.sv
hdl/cit_checker.sv
dv/cit_result_checker.sv
dv/tb_cru_interrupt_timer_controller.sv
